// File: rtl/core/wildcard_byte_pattern_search_core_defines.svh
// assertion macros for the pattern search core
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_CORE_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define WBPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define WBPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/wbps_pkg.sv
`timescale 1ns / 1ps

package wbps_pkg;

    localparam int PATTERN_MAX   = 32;
    localparam int ADDRESS_BITS  = 48;
    localparam int DATA_BITS     = 8;
    localparam int PAT_BYTES     = 32;
    localparam int GROUP_BYTES   = 8;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_BITS  = 3;
    localparam int LEN_REG_BITS  = 6;
    localparam int LEN_LIMIT     = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
    localparam int LEN_BITS      = $clog2(PATTERN_MAX + 1);
    localparam int PAT_IDX_BITS  = $clog2(PAT_BYTES);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BASE_ADDRESS   = 3'd0,
        REG_PATTERN_0      = 3'd1,
        REG_PATTERN_1      = 3'd2,
        REG_PATTERN_2      = 3'd3,
        REG_PATTERN_3      = 3'd4,
        REG_WILDCARD_MASK  = 3'd5,
        REG_PATTERN_LENGTH = 3'd6
    } cfg_reg_t;

endpackage

// File: rtl/core/wildcard_byte_pattern_search_core.sv
// the result beat is registered: it is on m_tvalid in the cycle after the input beat that completes it
// throughput: one input beat per cycle, back to back, while the result register drains
// the result register stalls input only while it holds a beat that m_tready has not taken
// reset: rst_n asynchronous, active low; clears index, fill and done scan state, output valid
// and config registers (pattern length resets to 1, all others to 0); the byte window is not reset
`timescale 1ns / 1ps
`include "wildcard_byte_pattern_search_core_defines.svh"

module wildcard_byte_pattern_search_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // input stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [wbps_pkg::DATA_BITS-1:0]          s_tdata,   // data_byte
    input  logic                                    s_tuser,   // first_byte
    input  logic                                    s_tlast,   // last_byte
    // result stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [wbps_pkg::ADDRESS_BITS-1:0]       m_tdata,   // match_address
    output logic                                    m_tuser,   // found
    // config write port
    input  logic                                    cfg_we,
    input  logic [wbps_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [wbps_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    localparam int PM  = wbps_pkg::PATTERN_MAX;
    localparam int AB  = wbps_pkg::ADDRESS_BITS;
    localparam int DB  = wbps_pkg::DATA_BITS;
    localparam int LB  = wbps_pkg::LEN_BITS;
    localparam int PIB = wbps_pkg::PAT_IDX_BITS;
    localparam int PB  = wbps_pkg::PAT_BYTES;
    localparam int GB  = wbps_pkg::GROUP_BYTES;

    // config registers
    logic [AB-1:0]                     base_reg;
    logic [PB-1:0][DB-1:0]             pattern_reg;
    logic [PB-1:0]                     wild_reg;
    logic [wbps_pkg::LEN_REG_BITS-1:0] length_reg;

    // scan state
    logic [PM-2:0][DB-1:0] window_reg, window_next;
    logic [AB-1:0]         index_reg, index_next;
    logic [LB-1:0]         fill_reg, fill_next;
    logic                  done_reg, done_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic                  out_found_reg, out_found_next;
    logic [AB-1:0]         out_addr_reg, out_addr_next;

    logic                  accept;
    logic [LB-1:0]         len_eff;
    logic [PM-1:0][DB-1:0] age_byte;
    logic [LB-1:0]         pat_idx [PM];
    logic [PM-1:0]         age_ok;
    logic                  window_hit;
    logic                  done_cur;
    logic [AB-1:0]         index_cur;
    logic [LB-1:0]         fill_cur;
    logic [LB-1:0]         fill_inc;
    logic                  match;
    logic                  produce;
    logic [AB-1:0]         start_addr;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = out_addr_reg;

    // zero counts as one, above the limit saturates
    always_comb
    begin
        if (length_reg == '0)
            len_eff = LB'(1);
        else if (length_reg > wbps_pkg::LEN_REG_BITS'(wbps_pkg::LEN_LIMIT))
            len_eff = LB'(wbps_pkg::LEN_LIMIT);
        else
            len_eff = LB'(length_reg);
    end

    // age 0 is the incoming byte, older bytes come from the window
    always_comb
    begin
        age_byte[0] = s_tdata;
        for (int a = 1; a < PM; a++)
        begin
            age_byte[a] = window_reg[a-1];
        end
    end

    // pattern byte for each window age, aligned by the current length
    always_comb
    begin
        for (int a = 0; a < PM; a++)
        begin
            pat_idx[a] = len_eff - LB'(1) - LB'(a);
            if (LB'(a) >= len_eff)
                age_ok[a] = 1'b1;
            else if (wild_reg[pat_idx[a][PIB-1:0]])
                age_ok[a] = 1'b1;
            else
                age_ok[a] = (age_byte[a] == pattern_reg[pat_idx[a][PIB-1:0]]);
        end
    end

    assign window_hit = &age_ok;

    always_comb
    begin
        done_cur   = s_tuser ? 1'b0 : done_reg;
        index_cur  = s_tuser ? '0 : index_reg;
        fill_cur   = s_tuser ? '0 : fill_reg;
        fill_inc   = (fill_cur == LB'(PM)) ? fill_cur : fill_cur + LB'(1);
        match      = !done_cur && (fill_inc >= len_eff) && window_hit;
        produce    = !done_cur && (match || s_tlast);
        start_addr = base_reg + index_cur - AB'(len_eff - LB'(1));

        window_next    = window_reg;
        index_next     = index_reg;
        fill_next      = fill_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_addr_next  = out_addr_reg;

        if (m_tready)
            out_valid_next = 1'b0;

        if (accept)
        begin
            index_next = index_cur;
            fill_next  = fill_cur;
            done_next  = done_cur;
            if (!done_cur)
            begin
                window_next = {window_reg[PM-3:0], s_tdata};
                fill_next   = fill_inc;
                done_next   = produce;
                if (produce)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = match;
                    out_addr_next  = match ? start_addr : '0;
                end
                else
                begin
                    index_next = index_cur + AB'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg     <= '0;
            fill_reg      <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            index_reg     <= index_next;
            fill_reg      <= fill_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        window_reg    <= window_next;
        out_found_reg <= out_found_next;
        out_addr_reg  <= out_addr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= '0;
            pattern_reg <= '0;
            wild_reg    <= '0;
            length_reg  <= wbps_pkg::LEN_REG_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (wbps_pkg::cfg_reg_t'(cfg_index))
                wbps_pkg::REG_BASE_ADDRESS:   base_reg <= cfg_data[AB-1:0];
                wbps_pkg::REG_PATTERN_0:      pattern_reg[GB-1:0] <= cfg_data;
                wbps_pkg::REG_PATTERN_1:      pattern_reg[2*GB-1:GB] <= cfg_data;
                wbps_pkg::REG_PATTERN_2:      pattern_reg[3*GB-1:2*GB] <= cfg_data;
                wbps_pkg::REG_PATTERN_3:      pattern_reg[4*GB-1:3*GB] <= cfg_data;
                wbps_pkg::REG_WILDCARD_MASK:  wild_reg <= cfg_data[PB-1:0];
                wbps_pkg::REG_PATTERN_LENGTH:
                    length_reg <= cfg_data[wbps_pkg::LEN_REG_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    `WBPS_ASSERT_SAME(a_notfound_zero, m_tvalid && !m_tuser, m_tdata == '0,
        "not-found beat carries a nonzero address")
    `WBPS_ASSERT_NEXT(a_result_sets_done, accept && produce, done_reg && m_tvalid,
        "result beat without done flag")
    `WBPS_ASSERT_NEXT(a_done_holds, accept && done_reg && !s_tuser,
        $stable(index_reg) && $stable(fill_reg) && done_reg,
        "scan state moved after the result")
    `WBPS_ASSERT_SAME(a_notfound_on_last, accept && produce && !match, s_tlast,
        "not-found given before the last byte")
    `WBPS_ASSERT_SAME(a_fill_bound, 1'b1, fill_reg <= LB'(PM),
        "fill count beyond window depth")

endmodule
